[rtl/btc_pkg.sv]
`timescale 1ns / 1ps

package btc_pkg;

  // activity state encoding
  localparam logic [2:0] ST_ASLEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_WAIT    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  // automatic tiers
  localparam logic [1:0] TIER_NONE  = 2'd0;
  localparam logic [1:0] TIER_DIM   = 2'd1;
  localparam logic [1:0] TIER_SLEEP = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STALE_DIM   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STALE_SLEEP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_DIM    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_FULL   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_HIGH   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_DIM    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_LOW    = 3'd7;

  localparam int CFG_DATA_BITS = 32;

  // reset values
  localparam logic [31:0] RST_STALE_DIM   = 32'd30000;
  localparam logic [31:0] RST_STALE_SLEEP = 32'd300000;
  localparam logic [31:0] RST_IDLE_DIM    = 32'd15000;
  localparam logic [15:0] RST_DEBOUNCE    = 16'd180;
  localparam logic [7:0]  RST_DUTY_FULL   = 8'd255;
  localparam logic [7:0]  RST_DUTY_HIGH   = 8'd160;
  localparam logic [7:0]  RST_DUTY_DIM    = 8'd70;
  localparam logic [7:0]  RST_DUTY_LOW    = 8'd20;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_released;
    logic        host_line_ok;
    logic        state_present;
    logic [2:0]  host_state;
  } in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [1:0] level_index;
    logic [2:0] shown_state;
    logic       manual_hold;
    logic       auto_dimmed;
  } out_t;

  typedef struct packed {
    logic [31:0]     dim_timeout;
    logic [31:0]     sleep_timeout;
    logic [31:0]     idle_timeout;
    logic [15:0]     debounce_ms;
    logic [3:0][7:0] duty;
  } cfg_t;

  // brightness level that each automatic tier forces
  function automatic logic [1:0] tier_level(input logic [1:0] tier);
    logic [1:0] lvl;
    case (tier)
      TIER_NONE:  lvl = 2'd0;
      TIER_DIM:   lvl = 2'd2;
      default:    lvl = 2'd3;
    endcase
    return lvl;
  endfunction

endpackage

[rtl/btc_cfg.sv]
`timescale 1ns / 1ps

module btc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [btc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [btc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output btc_pkg::cfg_t                       cfg
);
  import btc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_timeout    <= RST_STALE_DIM;
      cfg.sleep_timeout  <= RST_STALE_SLEEP;
      cfg.idle_timeout   <= RST_IDLE_DIM;
      cfg.debounce_ms    <= RST_DEBOUNCE;
      cfg.duty[0]        <= RST_DUTY_FULL;
      cfg.duty[1]        <= RST_DUTY_HIGH;
      cfg.duty[2]        <= RST_DUTY_DIM;
      cfg.duty[3]        <= RST_DUTY_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STALE_DIM:   cfg.dim_timeout    <= cfg_data;
        REG_STALE_SLEEP: cfg.sleep_timeout  <= cfg_data;
        REG_IDLE_DIM:    cfg.idle_timeout   <= cfg_data;
        REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_data[15:0];
        REG_DUTY_FULL:   cfg.duty[0]        <= cfg_data[7:0];
        REG_DUTY_HIGH:   cfg.duty[1]        <= cfg_data[7:0];
        REG_DUTY_DIM:    cfg.duty[2]        <= cfg_data[7:0];
        REG_DUTY_LOW:    cfg.duty[3]        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/btc_core.sv]
`timescale 1ns / 1ps

module btc_core #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  btc_pkg::in_t  item,
  input  btc_pkg::cfg_t cfg,
  output btc_pkg::out_t result
);
  import btc_pkg::*;

  logic [2:0]           host_activity;
  logic [TIME_BITS-1:0] state_entry_time;
  logic [TIME_BITS-1:0] last_data_time;
  logic [1:0]           bright_index;
  logic [1:0]           previous_tier;
  logic                 manual_flag;
  logic                 auto_flag;
  logic [TIME_BITS-1:0] last_press_time;
  logic                 prior_button_level;

  logic [2:0]           host_activity_next;
  logic [TIME_BITS-1:0] state_entry_time_next;
  logic [TIME_BITS-1:0] last_data_time_next;
  logic [1:0]           bright_index_next;
  logic [1:0]           previous_tier_next;
  logic                 manual_flag_next;
  logic                 auto_flag_next;
  logic [TIME_BITS-1:0] last_press_time_next;

  logic [TIME_BITS-1:0] now;
  logic                 line_acc;
  logic                 press;
  logic [1:0]           idx_btn;
  logic                 manual_btn;
  logic                 auto_btn;
  logic [TIME_BITS-1:0] since_data;
  logic [TIME_BITS-1:0] since_entry;
  logic [TIME_BITS-1:0] since_press;
  logic                 stale_sleep;
  logic                 stale_dim;
  logic [2:0]           shown;
  logic [1:0]           data_tier;
  logic [1:0]           state_tier;
  logic [1:0]           tier;

  assign now = item.now_ms[TIME_BITS-1:0];

  always_comb begin
    // host line; a state code out of range drops the whole line
    line_acc = item.host_line_ok && !(item.state_present && (item.host_state > ST_DONE));
    host_activity_next    = host_activity;
    state_entry_time_next = state_entry_time;
    if (line_acc && item.state_present && (item.host_state != host_activity)) begin
      host_activity_next    = item.host_state;
      state_entry_time_next = now;
    end
    last_data_time_next = line_acc ? now : last_data_time;

    // debounced press edge
    since_press = now - last_press_time;
    press = (item.button_released != prior_button_level) && !item.button_released &&
            (32'(since_press) >= 32'(cfg.debounce_ms));
    last_press_time_next = press ? now : last_press_time;
    idx_btn    = bright_index;
    auto_btn   = auto_flag;
    manual_btn = manual_flag;
    if (press) begin
      if (auto_flag) begin
        idx_btn  = 2'd0;
        auto_btn = 1'b0;
      end else begin
        idx_btn = bright_index + 2'd1;
      end
      manual_btn = 1'b1;
    end

    // staleness overrides and tiers
    since_data  = now - last_data_time_next;
    since_entry = now - state_entry_time_next;
    stale_sleep = 32'(since_data) >= cfg.sleep_timeout;
    stale_dim   = 32'(since_data) >= cfg.dim_timeout;
    if (stale_sleep) begin
      shown = ST_ASLEEP;
    end else if (stale_dim &&
                 (host_activity_next == ST_BUSY || host_activity_next == ST_WAIT)) begin
      shown = ST_IDLE;
    end else begin
      shown = host_activity_next;
    end

    if (stale_sleep) data_tier = TIER_SLEEP;
    else if (stale_dim) data_tier = TIER_DIM;
    else data_tier = TIER_NONE;

    if (shown == ST_ASLEEP) state_tier = TIER_SLEEP;
    else if (shown == ST_IDLE && 32'(since_entry) >= cfg.idle_timeout) state_tier = TIER_DIM;
    else state_tier = TIER_NONE;

    tier = (state_tier > data_tier) ? state_tier : data_tier;

    previous_tier_next = previous_tier;
    bright_index_next  = idx_btn;
    manual_flag_next   = manual_btn;
    auto_flag_next     = auto_btn;
    if (tier != previous_tier) begin
      // tier change releases the manual hold
      previous_tier_next = tier;
      manual_flag_next   = 1'b0;
      auto_flag_next     = (tier != TIER_NONE);
      bright_index_next  = tier_level(tier);
    end else if (!manual_btn) begin
      auto_flag_next    = (tier != TIER_NONE);
      bright_index_next = tier_level(tier);
    end

    result.duty        = cfg.duty[bright_index_next];
    result.level_index = bright_index_next;
    result.shown_state = shown;
    result.manual_hold = manual_flag_next;
    result.auto_dimmed = auto_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_activity      <= ST_IDLE;
      state_entry_time   <= '0;
      last_data_time     <= '0;
      bright_index       <= 2'd0;
      previous_tier      <= TIER_NONE;
      manual_flag        <= 1'b0;
      auto_flag          <= 1'b0;
      last_press_time    <= '0;
      prior_button_level <= 1'b1;
    end else if (step) begin
      host_activity      <= host_activity_next;
      state_entry_time   <= state_entry_time_next;
      last_data_time     <= last_data_time_next;
      bright_index       <= bright_index_next;
      previous_tier      <= previous_tier_next;
      manual_flag        <= manual_flag_next;
      auto_flag          <= auto_flag_next;
      last_press_time    <= last_press_time_next;
      prior_button_level <= item.button_released;
    end
  end

endmodule

[rtl/backlight_tier_controller_top.sv]
`timescale 1ns / 1ps
// Datapath: the input register loads at the accepting edge and the result register then loads
// from it; the state update runs at the same edge as the result register load.
// Throughput: one transaction per clock while out_ready takes the output; the state feedback loop
// through btc_core runs combinationally into the state registers, so back-to-back polls need no stalls.
// Reset (rst, synchronous, active high) empties both registers, restores the default
// configuration and returns the controller state to idle at full brightness.
module backlight_tier_controller_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  btc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output btc_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [btc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import btc_pkg::*;

  cfg_t cfg;
  in_t  item;
  logic item_valid;
  logic advance;
  logic step;
  out_t result;

  assign advance  = !out_valid || out_ready;
  assign step     = item_valid && advance;
  assign in_ready = !item_valid || advance;

  btc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import btc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [1:0] LEVEL_OF_TIER [3] = '{2'd0, 2'd2, 2'd3};

  logic clk;
  logic rst = 1'b1;

  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_t                      in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  backlight_tier_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus and expectations
  in_t  poll_queue[$];
  out_t expected_status[$];
  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   pressure_on    = 1'b0;

  // controller shadow state
  cfg_t        shadow_cfg;
  logic [2:0]  sh_activity;
  logic [31:0] sh_entry_time;
  logic [31:0] sh_data_time;
  logic [1:0]  sh_bright;
  logic [1:0]  sh_prev_tier;
  logic        sh_manual;
  logic        sh_auto;
  logic [31:0] sh_press_time;
  logic        sh_button;

  // random generator state
  logic [31:0] gen_now    = '0;
  logic        gen_button = 1'b1;
  int          gen_line_pct = 30;

  task automatic reset_shadow();
    shadow_cfg.dim_timeout    = RST_STALE_DIM;
    shadow_cfg.sleep_timeout  = RST_STALE_SLEEP;
    shadow_cfg.idle_timeout   = RST_IDLE_DIM;
    shadow_cfg.debounce_ms    = RST_DEBOUNCE;
    shadow_cfg.duty[0]        = RST_DUTY_FULL;
    shadow_cfg.duty[1]        = RST_DUTY_HIGH;
    shadow_cfg.duty[2]        = RST_DUTY_DIM;
    shadow_cfg.duty[3]        = RST_DUTY_LOW;
    sh_activity   = ST_IDLE;
    sh_entry_time = '0;
    sh_data_time  = '0;
    sh_bright     = 2'd0;
    sh_prev_tier  = TIER_NONE;
    sh_manual     = 1'b0;
    sh_auto       = 1'b0;
    sh_press_time = '0;
    sh_button     = 1'b1;
  endtask

  // one poll of the controller: host line, button, then brightness
  function automatic void step_backlight(in_t p);
    logic [31:0] since;
    logic [2:0]  shown;
    logic [1:0]  tier;
    logic [1:0]  st_tier;
    out_t        r;
    if (p.host_line_ok && !(p.state_present && p.host_state > ST_DONE)) begin
      if (p.state_present && p.host_state != sh_activity) begin
        sh_activity   = p.host_state;
        sh_entry_time = p.now_ms;
      end
      sh_data_time = p.now_ms;
    end
    if (p.button_released != sh_button) begin
      sh_button = p.button_released;
      if (!p.button_released &&
          (p.now_ms - sh_press_time) >= {16'd0, shadow_cfg.debounce_ms}) begin
        sh_press_time = p.now_ms;
        if (sh_auto) begin
          sh_bright = 2'd0;
          sh_auto   = 1'b0;
        end else begin
          sh_bright = sh_bright + 2'd1;
        end
        sh_manual = 1'b1;
      end
    end
    since = p.now_ms - sh_data_time;
    if (since >= shadow_cfg.sleep_timeout) begin
      shown = ST_ASLEEP;
    end else if (since >= shadow_cfg.dim_timeout &&
                 (sh_activity == ST_BUSY || sh_activity == ST_WAIT)) begin
      shown = ST_IDLE;
    end else begin
      shown = sh_activity;
    end
    if (since >= shadow_cfg.sleep_timeout) tier = TIER_SLEEP;
    else if (since >= shadow_cfg.dim_timeout) tier = TIER_DIM;
    else tier = TIER_NONE;
    st_tier = TIER_NONE;
    if (shown == ST_ASLEEP) begin
      st_tier = TIER_SLEEP;
    end else if (shown == ST_IDLE &&
                 (p.now_ms - sh_entry_time) >= shadow_cfg.idle_timeout) begin
      st_tier = TIER_DIM;
    end
    if (st_tier > tier) tier = st_tier;
    if (tier != sh_prev_tier) begin
      sh_prev_tier = tier;
      sh_manual    = 1'b0;
      sh_auto      = (tier != TIER_NONE);
      sh_bright    = LEVEL_OF_TIER[tier];
    end else if (!sh_manual) begin
      sh_auto   = (tier != TIER_NONE);
      sh_bright = LEVEL_OF_TIER[tier];
    end
    r.duty        = shadow_cfg.duty[sh_bright];
    r.level_index = sh_bright;
    r.shown_state = shown;
    r.manual_hold = sh_manual;
    r.auto_dimmed = sh_auto;
    expected_status.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_backlight(in_data);
      end
      if (!in_valid || in_ready) begin
        if (poll_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= poll_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // monitor
  out_t want;
  int   hold_cnt  = 0;
  bit   hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual %h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("duty", want.duty, out_data.duty);
          check_field("level_index", 8'(want.level_index), 8'(out_data.level_index));
          check_field("shown_state", 8'(want.shown_state), 8'(out_data.shown_state));
          check_field("manual_hold", 8'(want.manual_hold), 8'(out_data.manual_hold));
          check_field("auto_dimmed", 8'(want.auto_dimmed), 8'(out_data.auto_dimmed));
        end
      end
      // long hold-off once, so the input side backs up
      if (pressure_on && !hold_done) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: cycles without any transaction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_STALE_DIM:   shadow_cfg.dim_timeout    = val;
      REG_STALE_SLEEP: shadow_cfg.sleep_timeout  = val;
      REG_IDLE_DIM:    shadow_cfg.idle_timeout   = val;
      REG_DEBOUNCE:    shadow_cfg.debounce_ms    = val[15:0];
      REG_DUTY_FULL:   shadow_cfg.duty[0]        = val[7:0];
      REG_DUTY_HIGH:   shadow_cfg.duty[1]        = val[7:0];
      REG_DUTY_DIM:    shadow_cfg.duty[2]        = val[7:0];
      REG_DUTY_LOW:    shadow_cfg.duty[3]        = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_cfg(logic [31:0] sd, logic [31:0] ss, logic [31:0] idl,
                             logic [31:0] db, logic [31:0] d0, logic [31:0] d1,
                             logic [31:0] d2, logic [31:0] d3);
    cfg_write(REG_STALE_DIM, sd);
    cfg_write(REG_STALE_SLEEP, ss);
    cfg_write(REG_IDLE_DIM, idl);
    cfg_write(REG_DEBOUNCE, db);
    cfg_write(REG_DUTY_FULL, d0);
    cfg_write(REG_DUTY_HIGH, d1);
    cfg_write(REG_DUTY_DIM, d2);
    cfg_write(REG_DUTY_LOW, d3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // short thresholds so tiers change often; upper data bits exercise masking
  task automatic program_small_cfg();
    logic [31:0] sd;
    logic [31:0] ss;
    sd = $urandom_range(20, 600);
    ss = ($urandom_range(9) == 0) ? $urandom_range(0, 300) : sd + $urandom_range(0, 2000);
    program_cfg(sd, ss, $urandom_range(10, 500),
                ($urandom & 32'hFFFF_0000) | $urandom_range(0, 80),
                $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic add_poll(logic [31:0] now, logic btn, logic ok, logic sp, logic [2:0] hs);
    in_t p;
    p.now_ms          = now;
    p.button_released = btn;
    p.host_line_ok    = ok;
    p.state_present   = sp;
    p.host_state      = hs;
    poll_queue.push_back(p);
  endtask

  task automatic add_random_polls(int n);
    int r;
    logic [2:0] hs;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: gen_line_pct = 0;
          1: gen_line_pct = 5;
          2: gen_line_pct = 30;
          default: gen_line_pct = 80;
        endcase
      end
      r = $urandom_range(99);
      if (r < 55) gen_now = gen_now + $urandom_range(0, 40);
      else if (r < 85) gen_now = gen_now + $urandom_range(0, 400);
      else if (r < 95) gen_now = gen_now + $urandom_range(0, 3000);
      else gen_now = $urandom;
      if ($urandom_range(99) < 35) gen_button = ~gen_button;
      hs = ($urandom_range(99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      add_poll(gen_now, gen_button, $urandom_range(99) < gen_line_pct,
               $urandom_range(99) < 70, hs);
    end
  endtask

  task automatic drain();
    while (poll_queue.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n, int s_idle, int r_stall);
    @(negedge clk);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    add_random_polls(n);
    drain();
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset configuration
    @(negedge clk);
    add_poll(32'd0,      1'b1, 1'b0, 1'b0, ST_ASLEEP);
    add_poll(32'd100,    1'b0, 1'b0, 1'b0, ST_ASLEEP);  // bounced press
    add_poll(32'd150,    1'b1, 1'b0, 1'b0, ST_ASLEEP);
    add_poll(32'd400,    1'b0, 1'b1, 1'b1, ST_BUSY);    // press and new state
    add_poll(32'd450,    1'b1, 1'b1, 1'b1, ST_BUSY);    // repeated state
    add_poll(32'd500,    1'b0, 1'b0, 1'b0, ST_ASLEEP);  // bounced press
    add_poll(32'd700,    1'b1, 1'b1, 1'b1, 3'd5);       // unknown state code
    add_poll(32'd800,    1'b1, 1'b1, 1'b1, 3'd7);
    add_poll(32'd900,    1'b1, 1'b0, 1'b1, ST_WAIT);    // no host line
    add_poll(32'd1000,   1'b1, 1'b1, 1'b0, ST_DONE);    // line without state
    add_poll(32'd40000,  1'b1, 1'b0, 1'b0, ST_ASLEEP);  // stale: busy falls back
    add_poll(32'd40500,  1'b0, 1'b0, 1'b0, ST_ASLEEP);  // press wakes from auto
    add_poll(32'd40600,  1'b1, 1'b0, 1'b0, ST_ASLEEP);
    add_poll(32'd41000,  1'b0, 1'b0, 1'b0, ST_ASLEEP);  // press cycles level
    add_poll(32'd400000, 1'b1, 1'b0, 1'b0, ST_ASLEEP);  // forced sleep
    add_poll(32'd400100, 1'b1, 1'b1, 1'b1, ST_ASLEEP);
    add_poll(32'd400200, 1'b1, 1'b1, 1'b1, ST_IDLE);
    add_poll(32'd420000, 1'b1, 1'b0, 1'b0, ST_ASLEEP);  // idle held long enough
    add_poll(32'd420100, 1'b1, 1'b1, 1'b1, ST_WAIT);
    add_poll(32'd420200, 1'b1, 1'b1, 1'b1, ST_DONE);
    add_poll(32'hFFFF_FF00, 1'b1, 1'b1, 1'b1, ST_BUSY);
    add_poll(32'h0000_0040, 1'b0, 1'b0, 1'b0, ST_ASLEEP); // time wraps
    add_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 3'd6);
    add_poll(32'h8000_0000, 1'b1, 1'b1, 1'b0, ST_ASLEEP);
    drain();
    gen_now    = 32'h8000_0000;
    gen_button = 1'b1;

    run_random(150, 0, 0);
    program_small_cfg();
    run_random(300, 0, 0);
    program_small_cfg();
    run_random(300, 76, 0);
    program_small_cfg();
    run_random(300, 0, 76);
    program_small_cfg();
    run_random(250, 34, 34);

    // all-zero extremes, with one long receiver hold-off
    program_cfg('0, '0, '0, '0, '0, '0, '0, '0);
    @(negedge clk);
    pressure_on = 1'b1;
    run_random(200, 0, 0);

    // all-ones extremes
    program_cfg('1, '1, '1, '1, '1, '1, '1, '1);
    run_random(150, 34, 34);

    // full-range random thresholds
    program_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    run_random(150, 0, 0);

    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/btc_pkg.sv
rtl/btc_cfg.sv
rtl/btc_core.sv
rtl/backlight_tier_controller_top.sv
tb/sv/tb.sv
